/* rtl/sgba_pkg.sv */
// shared types, constants and codes of the grid binning block
package sgba_pkg;

    localparam int GRID_CELLS = 4096;
    localparam int AXES       = 3;
    localparam int CELL_W     = $clog2(GRID_CELLS);
    localparam int QDEPTH     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_UNDEF = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FILL   = 3'd6;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_DIRECT = 2'd3;

    typedef struct packed {
        logic        [1:0]  command;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
        logic signed [15:0] sample_value;
        logic        [11:0] cell_index;
    } t_in;

    typedef struct packed {
        logic signed [15:0] cell_value;
        logic        [15:0] cell_count;
        logic        [1:0]  status;
    } t_out;

    typedef struct packed {
        logic signed [11:0] min_x;
        logic signed [11:0] min_y;
        logic signed [11:0] min_z;
        logic        [12:0] size_x;
        logic        [12:0] size_y;
        logic        [12:0] size_z;
        logic signed [15:0] empty_value;
    } t_cfg;

    typedef struct packed {
        logic        [1:0]        op;
        logic        [CELL_W-1:0] idx;
        logic signed [15:0]       value;
        logic        [1:0]        status;
    } t_job;

endpackage

/* rtl/sgba_front.sv */
// front end: rounds coordinates, checks the grid and forms the cell index
module sgba_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sgba_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  sgba_pkg::t_in    i_data,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output sgba_pkg::t_job   o_push_data
);

    typedef enum logic [1:0] {F_IDLE, F_SHIFT, F_MUL, F_IDX} t_fstate;

    t_fstate            r_state;
    sgba_pkg::t_in      r_item;
    logic signed [13:0] r_sx, r_sy, r_sz;
    logic               r_inside;
    logic [25:0]        r_pxy;
    logic [38:0]        r_total;
    logic [39:0]        r_part;

    function automatic logic signed [12:0] round_q4(input logic signed [15:0] c);
        logic signed [16:0] cw;
        logic [16:0]        mag;
        logic [16:0]        r;
        begin
            cw  = 17'(c);
            mag = c[15] ? 17'(-cw) : 17'(cw);
            r   = (mag + 17'd8) >> 4;
            return c[15] ? -$signed(13'(r)) : $signed(13'(r));
        end
    endfunction

    logic [12:0]        w_size_y, w_size_z;
    logic signed [13:0] w_sx, w_sy, w_sz;
    logic               w_in_x, w_in_y, w_in_z;
    logic [25:0]        w_yp;
    logic [38:0]        w_zp;
    logic [39:0]        w_idx;
    logic [31:0]        w_ridx;

    assign w_size_y = (sgba_pkg::AXES > 1) ? i_cfg.size_y : 13'd1;
    assign w_size_z = (sgba_pkg::AXES > 2) ? i_cfg.size_z : 13'd1;

    assign w_sx = 14'(round_q4(r_item.coord_x)) - 14'(i_cfg.min_x);
    assign w_sy = 14'(round_q4(r_item.coord_y)) - 14'(i_cfg.min_y);
    assign w_sz = 14'(round_q4(r_item.coord_z)) - 14'(i_cfg.min_z);

    assign w_in_x = !w_sx[13] && (w_sx[12:0] < i_cfg.size_x);
    assign w_in_y = (sgba_pkg::AXES < 2) || (!w_sy[13] && (w_sy[12:0] < i_cfg.size_y));
    assign w_in_z = (sgba_pkg::AXES < 3) || (!w_sz[13] && (w_sz[12:0] < i_cfg.size_z));

    assign w_yp   = r_sy[12:0] * i_cfg.size_x;
    assign w_zp   = r_sz[12:0] * r_pxy;
    assign w_idx  = r_part + 40'(w_zp);
    assign w_ridx = 32'(r_item.cell_index);

    assign o_ready      = (r_state == F_IDLE);
    assign o_push_valid = (r_state == F_IDX);

    always_comb begin
        o_push_data        = '0;
        o_push_data.value  = r_item.sample_value;
        o_push_data.status = sgba_pkg::ST_OK;
        case (r_item.command)
            sgba_pkg::CMD_CLEAR: begin
                o_push_data.op = sgba_pkg::OP_CLEAR;
            end
            sgba_pkg::CMD_ADD: begin
                o_push_data.idx = w_idx[sgba_pkg::CELL_W-1:0];
                if (r_total > 39'(sgba_pkg::GRID_CELLS)) begin
                    o_push_data.op     = sgba_pkg::OP_DIRECT;
                    o_push_data.status = sgba_pkg::ST_TOO_BIG;
                end else if (!r_inside || w_idx >= 40'(sgba_pkg::GRID_CELLS)) begin
                    o_push_data.op     = sgba_pkg::OP_DIRECT;
                    o_push_data.status = sgba_pkg::ST_OUTSIDE;
                end else begin
                    o_push_data.op = sgba_pkg::OP_ADD;
                end
            end
            sgba_pkg::CMD_READ: begin
                o_push_data.idx = w_ridx[sgba_pkg::CELL_W-1:0];
                if (w_ridx >= 32'(sgba_pkg::GRID_CELLS)) begin
                    o_push_data.op     = sgba_pkg::OP_DIRECT;
                    o_push_data.status = sgba_pkg::ST_OUTSIDE;
                end else begin
                    o_push_data.op = sgba_pkg::OP_READ;
                end
            end
            default: begin
                o_push_data.op = sgba_pkg::OP_DIRECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_item  <= i_data;
                        r_state <= F_SHIFT;
                    end
                end
                F_SHIFT: begin
                    r_sx     <= w_sx;
                    r_sy     <= (sgba_pkg::AXES > 1) ? w_sy : 14'sd0;
                    r_sz     <= (sgba_pkg::AXES > 2) ? w_sz : 14'sd0;
                    r_inside <= w_in_x && w_in_y && w_in_z;
                    r_pxy    <= i_cfg.size_x * w_size_y;
                    r_state  <= F_MUL;
                end
                F_MUL: begin
                    r_total <= r_pxy * w_size_z;
                    r_part  <= 40'(r_sx[12:0]) + 40'(w_yp);
                    r_state <= F_IDX;
                end
                F_IDX: begin
                    if (i_push_ready) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

/* rtl/sgba_queue.sv */
// short request queue between front and back
module sgba_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  sgba_pkg::t_job i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output sgba_pkg::t_job o_pop_data
);

    localparam int PTR_W = $clog2(sgba_pkg::QDEPTH);
    localparam int CNT_W = $clog2(sgba_pkg::QDEPTH + 1);

    sgba_pkg::t_job   r_slot [sgba_pkg::QDEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_push_ready = (r_cnt != CNT_W'(sgba_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_slot[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(sgba_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(sgba_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

/* rtl/sgba_back.sv */
// back end: cell store, running average with serial divider, clearing sweep
module sgba_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sgba_pkg::t_cfg i_cfg,
    input  logic           i_job_valid,
    output logic           o_job_ready,
    input  sgba_pkg::t_job i_job_data,
    output logic           o_init,
    output logic           o_valid,
    input  logic           i_ready,
    output sgba_pkg::t_out o_data
);

    localparam int CW = sgba_pkg::CELL_W;

    typedef enum logic [2:0] {
        S_SWEEP, S_IDLE, S_RD, S_EVAL, S_PREP, S_DIV, S_WB, S_DONE
    } t_bstate;

    t_bstate            r_state;
    logic [31:0]        r_mem [sgba_pkg::GRID_CELLS];
    logic [31:0]        r_rdata;
    logic [CW-1:0]      r_addr;
    logic [CW-1:0]      r_sweep;
    logic               r_reply;
    sgba_pkg::t_job     r_job;
    sgba_pkg::t_out     r_res;
    sgba_pkg::t_out     r_out;
    logic               r_out_valid;
    logic signed [33:0] r_num;
    logic [16:0]        r_den;
    logic [15:0]        r_cnt_new;
    logic               r_neg;
    logic [31:0]        r_nq;
    logic [16:0]        r_rem;
    logic [4:0]         r_step;

    logic signed [15:0] w_old;
    logic [15:0]        w_cnt;
    logic signed [32:0] w_prod;
    logic [33:0]        w_mag;
    logic [17:0]        w_trial;
    logic               w_fit;
    logic [31:0]        w_q;
    logic               w_we;
    logic [CW-1:0]      w_wa;
    logic [31:0]        w_wd;
    logic               w_load;

    assign w_old   = $signed(r_rdata[31:16]);
    assign w_cnt   = r_rdata[15:0];
    assign w_prod  = w_old * $signed({1'b0, w_cnt});
    assign w_mag   = r_num[33] ? 34'(-r_num) : 34'(r_num);
    assign w_trial = {r_rem, r_nq[31]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_q     = r_neg ? 32'(-r_nq) : r_nq;
    assign w_load  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    assign o_job_ready = (r_state == S_IDLE);
    assign o_init      = (r_state == S_SWEEP) && !r_reply;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = '0;
        case (r_state)
            S_SWEEP: begin
                w_we = 1'b1;
                w_wa = r_sweep;
            end
            S_EVAL: begin
                if (r_job.op == sgba_pkg::OP_ADD && w_cnt == '0) begin
                    w_we = 1'b1;
                    w_wd = {r_job.value, 16'd1};
                end
            end
            S_WB: begin
                w_we = 1'b1;
                w_wd = {w_q[15:0], r_cnt_new};
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rdata <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_sweep     <= '0;
            r_reply     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out       <= r_res;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == CW'(sgba_pkg::GRID_CELLS - 1)) begin
                        r_reply <= 1'b0;
                        r_state <= r_reply ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job  <= i_job_data;
                        r_addr <= i_job_data.idx;
                        r_res  <= {i_cfg.empty_value, 16'd0, i_job_data.status};
                        case (i_job_data.op)
                            sgba_pkg::OP_CLEAR: begin
                                r_reply <= 1'b1;
                                r_sweep <= '0;
                                r_state <= S_SWEEP;
                            end
                            sgba_pkg::OP_ADD, sgba_pkg::OP_READ: r_state <= S_RD;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD: r_state <= S_EVAL;
                S_EVAL: begin
                    if (r_job.op == sgba_pkg::OP_READ) begin
                        if (w_cnt == '0) begin
                            r_res <= {i_cfg.empty_value, 16'd0, sgba_pkg::ST_OK};
                        end else begin
                            r_res <= {w_old, w_cnt, sgba_pkg::ST_OK};
                        end
                        r_state <= S_DONE;
                    end else if (w_cnt == '0) begin
                        r_res   <= {r_job.value, 16'd1, sgba_pkg::ST_OK};
                        r_state <= S_DONE;
                    end else begin
                        r_num     <= 34'(w_prod) + 34'(r_job.value);
                        r_den     <= 17'(w_cnt) + 17'd1;
                        r_cnt_new <= (w_cnt == 16'hFFFF) ? w_cnt : w_cnt + 16'd1;
                        r_state   <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_neg   <= r_num[33];
                    r_nq    <= w_mag[31:0];
                    r_rem   <= '0;
                    r_step  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= w_fit ? 17'(w_trial - {1'b0, r_den}) : w_trial[16:0];
                    r_nq   <= {r_nq[30:0], w_fit};
                    r_step <= r_step + 1'b1;
                    if (r_step == 5'd31) begin
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    r_res   <= {w_q[15:0], r_cnt_new, sgba_pkg::ST_OK};
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/scatter_to_grid_binning_average.sv */
// grid binning top: configuration registers, front end, queue and back end
// front takes a new request only once it has pushed the last one into the queue;
// back takes a new job only once the last result is loaded for output,
// and a filled add runs the 32-step serial divider, which other requests skip
// clear sweeps one cell per cycle, result valid once the sweep is done
// synchronous active-low reset; a sweep then zeroes all cell counts, no request until done
module scatter_to_grid_binning_average (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sgba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sgba_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sgba_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output sgba_pkg::t_out                     o_out_data
);

    sgba_pkg::t_cfg r_cfg;
    logic           w_front_ready;
    logic           w_init;
    logic           w_push_valid, w_push_ready;
    sgba_pkg::t_job w_push_data;
    logic           w_pop_valid, w_pop_ready;
    sgba_pkg::t_job w_pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_x       <= '0;
            r_cfg.min_y       <= '0;
            r_cfg.min_z       <= '0;
            r_cfg.size_x      <= 13'd16;
            r_cfg.size_y      <= 13'd16;
            r_cfg.size_z      <= 13'd16;
            r_cfg.empty_value <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgba_pkg::REG_MIN_X:  r_cfg.min_x       <= i_cfg_data[11:0];
                sgba_pkg::REG_MIN_Y:  r_cfg.min_y       <= i_cfg_data[11:0];
                sgba_pkg::REG_MIN_Z:  r_cfg.min_z       <= i_cfg_data[11:0];
                sgba_pkg::REG_SIZE_X: r_cfg.size_x      <= i_cfg_data[12:0];
                sgba_pkg::REG_SIZE_Y: r_cfg.size_y      <= i_cfg_data[12:0];
                sgba_pkg::REG_SIZE_Z: r_cfg.size_z      <= i_cfg_data[12:0];
                sgba_pkg::REG_FILL:   r_cfg.empty_value <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = w_front_ready && !w_init;

    sgba_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid && !w_init),
        .o_ready      (w_front_ready),
        .i_data       (i_in_data),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    sgba_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    sgba_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (w_pop_valid),
        .o_job_ready (w_pop_ready),
        .i_job_data  (w_pop_data),
        .o_init      (w_init),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_data      (o_out_data)
    );

endmodule

/* tb/tb.sv */
// self-checking testbench of the grid binning block with a running-average predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgba_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    scatter_to_grid_binning_average u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_in_data(i_in_data), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_cfg grid_cfg;
    logic [15:0] avg_store [GRID_CELLS];
    logic [15:0] hit_store [GRID_CELLS];
    t_in request_q [$];
    t_out expected_q [$];
    int mismatches = 0;
    bit quiet = 1'b0;
    int in_gap = 0, out_gap = 0;

    function automatic int round_coord(logic signed [15:0] c);
        int v;
        v = c;
        if (v >= 0) return (v + 8) >>> 4;
        return -((-v + 8) >>> 4);
    endfunction

    function automatic t_out bin_point(t_in r);
        t_out o;
        int crd[3], mn[3], sz[3], sh;
        longint total, stride, idx, old, n, avg;
        o.cell_value = grid_cfg.empty_value;
        o.cell_count = '0;
        o.status = ST_OK;
        case (r.command)
            CMD_CLEAR: begin
                for (int i = 0; i < GRID_CELLS; i++) hit_store[i] = '0;
            end
            CMD_ADD: begin
                crd[0] = round_coord(r.coord_x);
                crd[1] = round_coord(r.coord_y);
                crd[2] = round_coord(r.coord_z);
                mn[0] = grid_cfg.min_x; mn[1] = grid_cfg.min_y; mn[2] = grid_cfg.min_z;
                sz[0] = grid_cfg.size_x; sz[1] = grid_cfg.size_y; sz[2] = grid_cfg.size_z;
                total = 1; stride = 1; idx = 0;
                for (int a = 0; a < AXES; a++) total *= sz[a];
                if (total > GRID_CELLS) begin
                    o.status = ST_TOO_BIG;
                    return o;
                end
                for (int a = 0; a < AXES; a++) begin
                    sh = crd[a] - mn[a];
                    if (sh < 0 || sh >= sz[a]) begin
                        o.status = ST_OUTSIDE;
                        return o;
                    end
                    idx += sh * stride;
                    stride *= sz[a];
                end
                if (idx >= GRID_CELLS) begin
                    o.status = ST_OUTSIDE;
                    return o;
                end
                n = hit_store[idx];
                if (n == 0) avg = r.sample_value;
                else begin
                    old = $signed(avg_store[idx]);
                    avg = (old * n + r.sample_value) / (n + 1);
                end
                avg_store[idx] = avg[15:0];
                if (n < 65535) n++;
                hit_store[idx] = n[15:0];
                o.cell_value = avg[15:0];
                o.cell_count = n[15:0];
            end
            CMD_READ: begin
                if (hit_store[r.cell_index] != 0) begin
                    o.cell_value = avg_store[r.cell_index];
                    o.cell_count = hit_store[r.cell_index];
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            expected_q.push_back(bin_point(i_in_data));
            void'(request_q.pop_front());
        end
        if (in_gap > 0) begin
            in_gap <= in_gap - 1;
            i_in_valid <= 1'b0;
        end else if ((i_in_valid && !o_in_ready) ) begin
            i_in_valid <= 1'b1;
        end else if (request_q.size() > 0 && i_rst_n) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
                in_gap <= $urandom_range(1, 14);
                i_in_valid <= 1'b0;
            end else begin
                i_in_valid <= 1'b1;
                i_in_data <= request_q[0];
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out e;
        if (o_out_valid && i_out_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", o_out_data);
            end else begin
                e = expected_q.pop_front();
                if (o_out_data !== e) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", e, o_out_data);
                end
            end
        end
        if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            out_gap <= $urandom_range(1, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MIN_X:  grid_cfg.min_x = data[11:0];
            REG_MIN_Y:  grid_cfg.min_y = data[11:0];
            REG_MIN_Z:  grid_cfg.min_z = data[11:0];
            REG_SIZE_X: grid_cfg.size_x = data[12:0];
            REG_SIZE_Y: grid_cfg.size_y = data[12:0];
            REG_SIZE_Z: grid_cfg.size_z = data[12:0];
            default:    grid_cfg.empty_value = data;
        endcase
    endtask

    task automatic drain();
        while (request_q.size() > 0 || i_in_valid || expected_q.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic logic [15:0] q4_of(int g);
        return 16'(g * 16 + $signed(5'($urandom_range(0, 15))) - 8);
    endfunction

    // point that lands in the current grid, or near its border
    function automatic t_in grid_point(bit spill);
        t_in r;
        int e;
        r = '0;
        r.command = CMD_ADD;
        e = spill ? 2 : 0;
        r.coord_x = q4_of(grid_cfg.min_x + $urandom_range(0, grid_cfg.size_x - 1 + 2*e) - e);
        r.coord_y = q4_of(grid_cfg.min_y + $urandom_range(0, grid_cfg.size_y - 1 + 2*e) - e);
        r.coord_z = q4_of(grid_cfg.min_z + $urandom_range(0, grid_cfg.size_z - 1 + 2*e) - e);
        r.sample_value = 16'($urandom);
        r.cell_index = 12'($urandom);
        return r;
    endfunction

    task automatic random_phase(int count);
        t_in r;
        int k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 60) r = grid_point(k < 8);
            else if (k < 88) begin
                r = '0;
                r.command = CMD_READ;
                r.cell_index = 12'($urandom_range(0, 63));
                if (k < 72) r.cell_index = 12'($urandom);
                r.coord_x = 16'($urandom);
                r.sample_value = 16'($urandom);
            end else if (k < 94) begin
                r = t_in'(78'({$urandom, $urandom, $urandom}));
                r.command = CMD_ADD;
            end else if (k < 97) begin
                r = t_in'(78'({$urandom, $urandom, $urandom}));
                r.command = CMD_UNDEF;
            end else begin
                r = t_in'(78'({$urandom, $urandom, $urandom}));
                r.command = CMD_CLEAR;
            end
            request_q.push_back(r);
        end
        drain();
    endtask

    initial begin
        t_in r;
        grid_cfg = '{min_x: 0, min_y: 0, min_z: 0, size_x: 16, size_y: 16, size_z: 16,
                     empty_value: 0};
        for (int i = 0; i < GRID_CELLS; i++) begin
            avg_store[i] = '0;
            hit_store[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, rounding, outside, reads, undefined command, clear
        r = '0; r.command = CMD_ADD; r.sample_value = 16'sh7fff; request_q.push_back(r);
        r.sample_value = 16'sh8000; request_q.push_back(r);
        r.coord_x = 16'sd7; request_q.push_back(r);
        r.coord_x = 16'sd8; r.sample_value = 16'sd5; request_q.push_back(r);
        r.coord_x = -16'sd8; request_q.push_back(r);
        r.coord_x = -16'sd7; r.sample_value = -16'sd3; request_q.push_back(r);
        r.coord_x = 16'sh7fff; request_q.push_back(r);
        r.coord_x = 16'sh8000; request_q.push_back(r);
        r.coord_x = 16'd248; r.coord_y = 16'd248; r.coord_z = 16'd248;
        request_q.push_back(r);
        r.coord_y = 16'hffff; r.coord_z = 16'hffff; request_q.push_back(r);
        r = '0; r.command = CMD_READ; request_q.push_back(r);
        r.cell_index = 12'd1; request_q.push_back(r);
        r.cell_index = 12'hfff; request_q.push_back(r);
        r.command = CMD_UNDEF; r.coord_x = 16'hffff; r.sample_value = 16'hffff;
        request_q.push_back(r);
        r = '0; r.command = CMD_CLEAR; request_q.push_back(r);
        r.command = CMD_READ; request_q.push_back(r);
        drain();

        // extreme register settings
        set_reg(REG_FILL, 16'h8000);
        set_reg(REG_SIZE_X, 16'd4096);
        set_reg(REG_SIZE_Y, 16'd1);
        set_reg(REG_SIZE_Z, 16'd1);
        set_reg(REG_MIN_X, 16'h0800);
        set_reg(REG_MIN_Y, 16'h07ff);
        set_reg(REG_MIN_Z, 16'h0800);
        r = '0; r.command = CMD_ADD;
        r.coord_x = 16'h8000; r.coord_y = 16'h7ff0; r.coord_z = 16'h8000;
        r.sample_value = 16'sd100; request_q.push_back(r);
        r.coord_x = 16'h7fff; request_q.push_back(r);
        r.coord_x = 16'h7ff0; request_q.push_back(r);
        random_phase(150);

        set_reg(REG_SIZE_X, 16'd4097);
        set_reg(REG_FILL, 16'h7fff);
        random_phase(40);

        set_reg(REG_SIZE_X, 16'd0);
        random_phase(20);

        set_reg(REG_SIZE_X, 16'd4);
        set_reg(REG_SIZE_Y, 16'd4);
        set_reg(REG_SIZE_Z, 16'd2);
        set_reg(REG_MIN_X, 16'h0ffe);
        set_reg(REG_MIN_Y, 16'd3);
        set_reg(REG_MIN_Z, 16'h0fff);
        set_reg(REG_FILL, 16'h1234);
        random_phase(400);

        set_reg(REG_SIZE_X, 16'd16);
        set_reg(REG_SIZE_Y, 16'd16);
        set_reg(REG_SIZE_Z, 16'd16);
        set_reg(REG_MIN_X, 16'd0);
        set_reg(REG_MIN_Y, 16'd0);
        set_reg(REG_MIN_Z, 16'd0);
        random_phase(250);

        quiet = 1'b1;
        set_reg(REG_FILL, 16'd0);
        random_phase(190);

        if (mismatches == 0) $display("PASS scatter_to_grid_binning_average");
        else $display("FAIL scatter_to_grid_binning_average");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAIL scatter_to_grid_binning_average");
        $finish;
    end
endmodule
